### hw/rtl/csl_pkg.sv
// Shared types, item codes and register constants of the console serial line registers.
package csl_pkg;

  // Item kinds
  localparam logic [2:0] KIND_BUS_READ   = 3'd0;
  localparam logic [2:0] KIND_BUS_WWRITE = 3'd1;
  localparam logic [2:0] KIND_BUS_BWRITE = 3'd2;
  localparam logic [2:0] KIND_HOST_READ  = 3'd3;
  localparam logic [2:0] KIND_HOST_WRITE = 3'd4;
  localparam logic [2:0] KIND_BUS_RESET  = 3'd5;
  localparam logic [2:0] KIND_INT_QUERY  = 3'd6;

  // Bus word register index (byte offset bits 2:1)
  localparam logic [1:0] WIX_RCSR = 2'd0;
  localparam logic [1:0] WIX_RBUF = 2'd1;
  localparam logic [1:0] WIX_XCSR = 2'd2;
  localparam logic [1:0] WIX_XBUF = 2'd3;

  // Bus byte offsets that do something on a byte write
  localparam logic [2:0] BOFF_RCSR    = 3'd0;
  localparam logic [2:0] BOFF_XCSR    = 3'd4;
  localparam logic [2:0] BOFF_XBUF    = 3'd6;
  localparam logic [2:0] BOFF_XBUF_HI = 3'd7;

  // Host word indexes
  localparam logic [2:0] HIX_ID   = 3'd0;
  localparam logic [2:0] HIX_RX   = 3'd1;
  localparam logic [2:0] HIX_TX   = 3'd2;
  localparam logic [2:0] HIX_ADDR = 3'd3;

  // Constants
  localparam logic [31:0] ID_WORD     = 32'h444C1002;
  localparam logic [31:0] FILLER_WORD = 32'hDEADBEEF;
  localparam logic [7:0]  RX_VECTOR   = 8'o060;
  localparam logic [7:0]  TX_VECTOR   = 8'o064;
  localparam logic [17:0] BASE_ADDR   = 18'o777560;
  localparam logic [2:0]  INT_LEVEL   = 3'd4;
  localparam int          FLAG_POS    = 7;
  localparam int          IE_POS      = 6;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  bus_offset;
    logic [2:0]  host_index;
    logic [31:0] write_data;
    logic [2:0]  int_level;
  } csl_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        responded;
    logic [7:0]  int_vector;
  } csl_rsp_t;

endpackage

### hw/rtl/csl_in_reg.sv
// Input register stage: holds one accepted item until the register core takes it.
module csl_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  csl_pkg::csl_req_t req,
  input  logic              advance,
  output logic              stage_valid,
  output csl_pkg::csl_req_t stage_req
);
  import csl_pkg::*;

  // Stall only while a held item cannot move on
  assign req_stall = stage_valid && !advance;

  // Load a new item whenever the stage is free or emptying
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!req_stall) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      stage_req <= req;
    end
  end

endmodule

### hw/rtl/csl_core.sv
// Register core: status flags and buffers, read mux, interrupt vector and update rules.
module csl_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  csl_pkg::csl_req_t req,
  output csl_pkg::csl_rsp_t rsp
);
  import csl_pkg::*;

  logic        rx_done, rx_done_next;
  logic        rx_int_enable, rx_int_enable_next;
  logic [15:0] rx_buffer, rx_buffer_next;
  logic        tx_ready, tx_ready_next;
  logic        tx_int_enable, tx_int_enable_next;
  logic [15:0] tx_buffer, tx_buffer_next;
  logic        unit_enabled, unit_enabled_next;
  logic [7:0]  rx_status;
  logic [7:0]  tx_status;
  logic [1:0]  word_ix;

  assign rx_status = {rx_done, rx_int_enable, 6'd0};
  assign tx_status = {tx_ready, tx_int_enable, 6'd0};
  assign word_ix   = req.bus_offset[2:1];

  // Work out the result and the next state for the item in hand
  always_comb begin
    rx_done_next       = rx_done;
    rx_int_enable_next = rx_int_enable;
    rx_buffer_next     = rx_buffer;
    tx_ready_next      = tx_ready;
    tx_int_enable_next = tx_int_enable;
    tx_buffer_next     = tx_buffer;
    unit_enabled_next  = unit_enabled;
    rsp                = '0;
    case (req.kind)
      KIND_BUS_READ: begin
        if (unit_enabled) begin
          rsp.responded = 1'b1;
          case (word_ix)
            WIX_RCSR: rsp.read_data = {24'd0, rx_status};
            WIX_RBUF: begin
              rsp.read_data = {16'd0, rx_buffer};
              rx_done_next  = 1'b0;
            end
            WIX_XCSR: rsp.read_data = {24'd0, tx_status};
            default:  rsp.read_data = {16'd0, tx_buffer};
          endcase
        end
      end
      KIND_BUS_WWRITE: begin
        if (unit_enabled) begin
          rsp.responded = 1'b1;
          case (word_ix)
            WIX_RCSR: rx_int_enable_next = req.write_data[IE_POS];
            WIX_XCSR: tx_int_enable_next = req.write_data[IE_POS];
            WIX_XBUF: begin
              tx_buffer_next = {tx_buffer[15:8], req.write_data[7:0]};
              tx_ready_next  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      KIND_BUS_BWRITE: begin
        if (unit_enabled) begin
          rsp.responded = 1'b1;
          case (req.bus_offset)
            BOFF_RCSR: rx_int_enable_next = req.write_data[IE_POS];
            BOFF_XCSR: tx_int_enable_next = req.write_data[IE_POS];
            BOFF_XBUF: begin
              tx_buffer_next = {tx_buffer[15:8], req.write_data[7:0]};
              tx_ready_next  = 1'b0;
            end
            BOFF_XBUF_HI: tx_ready_next = 1'b0;
            default: ;
          endcase
        end
      end
      KIND_HOST_READ: begin
        case (req.host_index)
          HIX_ID:   rsp.read_data = ID_WORD;
          HIX_RX:   rsp.read_data = {rx_buffer, 8'd0, rx_status};
          HIX_TX:   rsp.read_data = {tx_buffer, 8'd0, tx_status};
          HIX_ADDR: rsp.read_data = {unit_enabled, 7'd0, RX_VECTOR[5:0], BASE_ADDR};
          default:  rsp.read_data = FILLER_WORD;
        endcase
      end
      KIND_HOST_WRITE: begin
        case (req.host_index)
          HIX_RX: begin
            rx_buffer_next = req.write_data[31:16];
            rx_done_next   = req.write_data[FLAG_POS];
          end
          HIX_TX:   tx_ready_next     = req.write_data[FLAG_POS];
          HIX_ADDR: unit_enabled_next = req.write_data[31];
          default: ;
        endcase
      end
      KIND_BUS_RESET: begin
        rx_done_next       = 1'b0;
        rx_int_enable_next = 1'b0;
        tx_ready_next      = 1'b1;
        tx_int_enable_next = 1'b0;
      end
      KIND_INT_QUERY: begin
        // Receive request wins over transmit
        if (req.int_level == INT_LEVEL && rx_done && rx_int_enable) begin
          rsp.int_vector = RX_VECTOR;
        end else if (req.int_level == INT_LEVEL && tx_ready && tx_int_enable) begin
          rsp.int_vector = TX_VECTOR;
        end
      end
      default: ;
    endcase
  end

  // Commit the state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_done       <= 1'b0;
      rx_int_enable <= 1'b0;
      rx_buffer     <= '0;
      tx_ready      <= 1'b1;
      tx_int_enable <= 1'b0;
      tx_buffer     <= '0;
      unit_enabled  <= 1'b0;
    end else if (fire) begin
      rx_done       <= rx_done_next;
      rx_int_enable <= rx_int_enable_next;
      rx_buffer     <= rx_buffer_next;
      tx_ready      <= tx_ready_next;
      tx_int_enable <= tx_int_enable_next;
      tx_buffer     <= tx_buffer_next;
      unit_enabled  <= unit_enabled_next;
    end
  end

endmodule

### hw/rtl/console_serial_line_registers.sv
// Top level of the console serial line registers: input stage, register core, result register.
// The block takes one item per clock while the result side is not stalled. An accepted item
// is held in the input register, then the register core decodes the item, updates the
// flags and buffers and loads the result register in the same cycle. While a result is
// stalled at the output the input register can still take one more item, so a stall on
// the result side reaches req_stall one item later. Reset leaves the receive side clear,
// transmit ready set and the unit disabled, so processor bus accesses are not answered
// until the host sets the enable bit.
module console_serial_line_registers (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  kind,
  input  logic [2:0]  bus_offset,
  input  logic [2:0]  host_index,
  input  logic [31:0] write_data,
  input  logic [2:0]  int_level,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] read_data,
  output logic        responded,
  output logic [7:0]  int_vector
);
  import csl_pkg::*;

  csl_req_t req;
  csl_req_t stage_req;
  csl_rsp_t core_rsp;
  logic     stage_valid;
  logic     advance;
  logic     fire;

  assign req = '{kind:       kind,
                 bus_offset: bus_offset,
                 host_index: host_index,
                 write_data: write_data,
                 int_level:  int_level};

  // Move on whenever the result register is empty or being taken
  assign advance = !rsp_valid || !rsp_stall;
  assign fire    = stage_valid && advance;

  csl_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_req   (stage_req)
  );

  csl_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (stage_req),
    .rsp  (core_rsp)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_data  <= core_rsp.read_data;
      responded  <= core_rsp.responded;
      int_vector <= core_rsp.int_vector;
    end
  end

endmodule

### hw/rtl/csl_checker.sv
// Port-level checks on the console serial line registers, bound to the top level.
module csl_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic [2:0]  kind,
  input logic [2:0]  bus_offset,
  input logic [2:0]  host_index,
  input logic [31:0] write_data,
  input logic [2:0]  int_level,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [31:0] read_data,
  input logic        responded,
  input logic [7:0]  int_vector
);
  import csl_pkg::*;

  // Hold a stalled input item
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(kind) && $stable(bus_offset)
      && $stable(host_index) && $stable(write_data) && $stable(int_level))
    else $error("stalled item changed or dropped");

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) && $stable(responded)
      && $stable(int_vector))
    else $error("stalled result changed or dropped");

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("result shown right after reset");

  // Only the two known vectors, and never on an answered bus access
  a_vector: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && int_vector != 8'd0 |->
      (int_vector == RX_VECTOR || int_vector == TX_VECTOR) && !responded
      && read_data == 32'd0)
    else $error("bad interrupt vector");

  // An answered bus access carries at most sixteen bits
  a_bus_width: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && responded |-> read_data[31:16] == 16'd0)
    else $error("bus read wider than a word");

endmodule

bind console_serial_line_registers csl_checker u_csl_checker (.*);

### dv/tb_console_serial_line_registers.sv
// Self-checking testbench for the console serial line registers.
module tb_console_serial_line_registers;
  import csl_pkg::*;

  // Kind code outside the defined set: the block must ignore it
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [2:0]  kind = '0;
  logic [2:0]  bus_offset = '0;
  logic [2:0]  host_index = '0;
  logic [31:0] write_data = '0;
  logic [2:0]  int_level = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [31:0] read_data;
  logic        responded;
  logic [7:0]  int_vector;

  console_serial_line_registers dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .kind       (kind),
    .bus_offset (bus_offset),
    .host_index (host_index),
    .write_data (write_data),
    .int_level  (int_level),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .read_data  (read_data),
    .responded  (responded),
    .int_vector (int_vector)
  );

  always #2 clk = ~clk;

  // Shadow copy of the register state
  logic        sh_rx_done, sh_rx_ie, sh_tx_ready, sh_tx_ie, sh_enabled;
  logic [15:0] sh_rx_buf, sh_tx_buf;

  csl_rsp_t pending_rsp[$];
  int       errors = 0;
  int       n_items = 0;
  int       n_bus = 0;
  int       n_host = 0;
  int       n_query = 0;
  int       n_vectors = 0;
  int       n_results = 0;
  logic     idle_on = 1'b0;
  int       hold_cycles = 0;
  int       held = 0;

  function automatic logic [7:0] status_bits(input logic flag, input logic ie);
    return {flag, ie, 6'd0};
  endfunction

  // Work out the result of one access and update the shadow registers
  function automatic csl_rsp_t serial_regs_access(input csl_req_t it);
    csl_rsp_t r;
    r = '0;
    case (it.kind)
      KIND_BUS_READ: if (sh_enabled) begin
        r.responded = 1'b1;
        case (it.bus_offset[2:1])
          WIX_RCSR: r.read_data = {24'd0, status_bits(sh_rx_done, sh_rx_ie)};
          WIX_RBUF: begin
            r.read_data = {16'd0, sh_rx_buf};
            sh_rx_done  = 1'b0;
          end
          WIX_XCSR: r.read_data = {24'd0, status_bits(sh_tx_ready, sh_tx_ie)};
          default:  r.read_data = {16'd0, sh_tx_buf};
        endcase
      end
      KIND_BUS_WWRITE: if (sh_enabled) begin
        r.responded = 1'b1;
        case (it.bus_offset[2:1])
          WIX_RCSR: sh_rx_ie = it.write_data[IE_POS];
          WIX_XCSR: sh_tx_ie = it.write_data[IE_POS];
          WIX_XBUF: begin
            sh_tx_buf[7:0] = it.write_data[7:0];
            sh_tx_ready    = 1'b0;
          end
          default: ;
        endcase
      end
      KIND_BUS_BWRITE: if (sh_enabled) begin
        r.responded = 1'b1;
        case (it.bus_offset)
          BOFF_RCSR: sh_rx_ie = it.write_data[IE_POS];
          BOFF_XCSR: sh_tx_ie = it.write_data[IE_POS];
          BOFF_XBUF: begin
            sh_tx_buf[7:0] = it.write_data[7:0];
            sh_tx_ready    = 1'b0;
          end
          BOFF_XBUF_HI: sh_tx_ready = 1'b0;
          default: ;
        endcase
      end
      KIND_HOST_READ: begin
        case (it.host_index)
          HIX_ID:   r.read_data = ID_WORD;
          HIX_RX:   r.read_data = {sh_rx_buf, 8'd0, status_bits(sh_rx_done, sh_rx_ie)};
          HIX_TX:   r.read_data = {sh_tx_buf, 8'd0, status_bits(sh_tx_ready, sh_tx_ie)};
          HIX_ADDR: r.read_data = (32'(sh_enabled) << 31) | (32'(RX_VECTOR) << 18)
                                  | 32'(BASE_ADDR);
          default:  r.read_data = FILLER_WORD;
        endcase
      end
      KIND_HOST_WRITE: begin
        case (it.host_index)
          HIX_RX: begin
            sh_rx_buf  = it.write_data[31:16];
            sh_rx_done = it.write_data[FLAG_POS];
          end
          HIX_TX:   sh_tx_ready = it.write_data[FLAG_POS];
          HIX_ADDR: sh_enabled  = it.write_data[31];
          default: ;
        endcase
      end
      KIND_BUS_RESET: begin
        sh_rx_done  = 1'b0;
        sh_rx_ie    = 1'b0;
        sh_tx_ready = 1'b1;
        sh_tx_ie    = 1'b0;
      end
      KIND_INT_QUERY: begin
        if (it.int_level == INT_LEVEL && sh_rx_done && sh_rx_ie)
          r.int_vector = RX_VECTOR;
        else if (it.int_level == INT_LEVEL && sh_tx_ready && sh_tx_ie)
          r.int_vector = TX_VECTOR;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic csl_req_t mk(input logic [2:0] k, input logic [2:0] off,
                                  input logic [2:0] hix, input logic [31:0] wd,
                                  input logic [2:0] lvl);
    csl_req_t it;
    it.kind       = k;
    it.bus_offset = off;
    it.host_index = hix;
    it.write_data = wd;
    it.int_level  = lvl;
    return it;
  endfunction

  // Random access, weighted so that the unit stays enabled most of the time
  function automatic csl_req_t random_access();
    csl_req_t it;
    int       pick;
    pick = $urandom_range(99);
    it.kind = (pick < 24) ? KIND_BUS_READ :
              (pick < 38) ? KIND_BUS_WWRITE :
              (pick < 52) ? KIND_BUS_BWRITE :
              (pick < 64) ? KIND_HOST_READ :
              (pick < 78) ? KIND_HOST_WRITE :
              (pick < 83) ? KIND_BUS_RESET :
              (pick < 97) ? KIND_INT_QUERY : KIND_UNUSED;
    it.bus_offset = 3'($urandom_range(7));
    it.host_index = 3'($urandom_range(7));
    it.write_data = $urandom;
    it.int_level  = ($urandom_range(1) == 0) ? INT_LEVEL : 3'($urandom_range(7));
    if (it.kind == KIND_HOST_WRITE && it.host_index == HIX_ADDR)
      it.write_data[31] = ($urandom_range(9) != 0);
    return it;
  endfunction

  // Offer one item, hold it until accepted, then record its expected result
  task automatic send_item(input csl_req_t it);
    while (idle_on && $urandom_range(99) < 6) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    kind       <= it.kind;
    bus_offset <= it.bus_offset;
    host_index <= it.host_index;
    write_data <= it.write_data;
    int_level  <= it.int_level;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_rsp.push_back(serial_regs_access(it));
    n_items++;
    case (it.kind)
      KIND_BUS_READ, KIND_BUS_WWRITE, KIND_BUS_BWRITE, KIND_BUS_RESET: n_bus++;
      KIND_HOST_READ, KIND_HOST_WRITE: n_host++;
      KIND_INT_QUERY: n_query++;
      default: ;
    endcase
  endtask

  // Check each result taken from the block against the oldest expectation
  always @(posedge clk) begin
    csl_rsp_t exp_rsp;
    if (!rst && rsp_valid && !rsp_stall) begin
      n_results++;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t unexpected result: read_data %h responded %b int_vector %o",
                 $time, read_data, responded, int_vector);
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (exp_rsp.int_vector != 8'd0) n_vectors++;
        if (exp_rsp.read_data !== read_data || exp_rsp.responded !== responded ||
            exp_rsp.int_vector !== int_vector) begin
          errors++;
          $display("%0t expected read_data %h responded %b int_vector %o",
                   $time, exp_rsp.read_data, exp_rsp.responded, exp_rsp.int_vector);
          $display("%0t actual   read_data %h responded %b int_vector %o",
                   $time, read_data, responded, int_vector);
        end
      end
    end
    // Hold off for any requested stretch, otherwise stall at random when idles are on
    if (held < hold_cycles) begin
      held      <= held + 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= idle_on && ($urandom_range(99) < 6);
    end
  end

  task automatic test_directed();
    // Identity, filler and address words, and bus accesses while disabled
    send_item(mk(KIND_HOST_READ,  3'd0, HIX_ID,   32'h0000_0000, 3'd0));
    send_item(mk(KIND_HOST_READ,  3'd7, 3'd7,     32'hFFFF_FFFF, 3'd7));
    send_item(mk(KIND_HOST_READ,  3'd0, 3'd4,     32'h0000_0000, 3'd0));
    send_item(mk(KIND_HOST_READ,  3'd0, HIX_ADDR, 32'h0000_0000, 3'd0));
    send_item(mk(KIND_BUS_READ,   3'd0, HIX_ID,   32'h0000_0000, 3'd0));
    send_item(mk(KIND_BUS_WWRITE, BOFF_XCSR, HIX_ID, 32'hFFFF_FFFF, 3'd0));
    // Enable the unit and load the receive side
    send_item(mk(KIND_HOST_WRITE, 3'd0, HIX_ADDR, 32'h8000_0000, 3'd0));
    send_item(mk(KIND_HOST_READ,  3'd0, HIX_ADDR, 32'h0000_0000, 3'd0));
    send_item(mk(KIND_HOST_WRITE, 3'd0, HIX_RX,   32'hFFFF_0080, 3'd0));
    // Word write with bit 0 of the offset set still reaches the receive status
    send_item(mk(KIND_BUS_WWRITE, 3'd1, HIX_ID,   32'h0000_0040, 3'd0));
    send_item(mk(KIND_INT_QUERY,  3'd0, HIX_ID,   32'h0000_0000, INT_LEVEL));
    send_item(mk(KIND_INT_QUERY,  3'd0, HIX_ID,   32'h0000_0000, 3'd3));
    send_item(mk(KIND_BUS_READ,   BOFF_RCSR, HIX_ID, 32'h0000_0000, 3'd0));
    send_item(mk(KIND_BUS_READ,   3'd3, HIX_ID,   32'h0000_0000, 3'd0));
    // Transmit side: interrupt, ignored receive buffer write, low byte load
    send_item(mk(KIND_BUS_BWRITE, BOFF_XCSR, HIX_ID, 32'h0000_0040, 3'd0));
    send_item(mk(KIND_INT_QUERY,  3'd0, HIX_ID,   32'h0000_0000, INT_LEVEL));
    send_item(mk(KIND_BUS_WWRITE, 3'd2, HIX_ID,   32'hFFFF_FFFF, 3'd0));
    send_item(mk(KIND_BUS_WWRITE, BOFF_XBUF, HIX_ID, 32'h1234_ABCD, 3'd0));
    send_item(mk(KIND_HOST_WRITE, 3'd0, HIX_TX,   32'h0000_0080, 3'd0));
    send_item(mk(KIND_BUS_BWRITE, BOFF_XBUF_HI, HIX_ID, 32'h0000_FFFF, 3'd0));
    send_item(mk(KIND_BUS_BWRITE, 3'd5, HIX_ID,   32'h0000_FFFF, 3'd0));
    send_item(mk(KIND_BUS_BWRITE, BOFF_XBUF, HIX_ID, 32'h0000_0055, 3'd0));
    send_item(mk(KIND_HOST_READ,  3'd0, HIX_TX,   32'h0000_0000, 3'd0));
    // Ignored host writes, bus reset and the unused kind
    send_item(mk(KIND_HOST_WRITE, 3'd0, HIX_ID,   32'hFFFF_FFFF, 3'd0));
    send_item(mk(KIND_HOST_WRITE, 3'd0, 3'd6,     32'hFFFF_FFFF, 3'd0));
    send_item(mk(KIND_BUS_RESET,  3'd0, HIX_ID,   32'h0000_0000, 3'd0));
    send_item(mk(KIND_BUS_READ,   BOFF_XCSR, HIX_ID, 32'h0000_0000, 3'd0));
    send_item(mk(KIND_UNUSED,     3'd7, 3'd7,     32'hFFFF_FFFF, 3'd7));
  endtask

  task automatic test_random_traffic(input int count, input logic with_idle);
    idle_on <= with_idle;
    repeat (count) send_item(random_access());
  endtask

  // Hold the output long enough for the block to fill and stall its input
  task automatic test_output_hold();
    idle_on     <= 1'b0;
    hold_cycles <= hold_cycles + 300;
    repeat (40) send_item(random_access());
  endtask

  initial begin
    sh_rx_done  = 1'b0;
    sh_rx_ie    = 1'b0;
    sh_rx_buf   = '0;
    sh_tx_ready = 1'b1;
    sh_tx_ie    = 1'b0;
    sh_tx_buf   = '0;
    sh_enabled  = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic(600, 1'b1);
    test_random_traffic(400, 1'b0);
    test_output_hold();
    test_random_traffic(350, 1'b1);

    // Drain: wait for every result, then allow the pipeline to settle
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d items: %0d processor bus, %0d host side, %0d interrupt queries.",
             n_items, n_bus, n_host, n_query);
    $display("Checked %0d results, %0d with a vector raised, across one long output hold.",
             n_results, n_vectors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #800000;
    $display("run timed out with %0d results outstanding", pending_rsp.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### console_serial_line_registers.f
hw/rtl/csl_pkg.sv
hw/rtl/csl_in_reg.sv
hw/rtl/csl_core.sv
hw/rtl/console_serial_line_registers.sv
hw/rtl/csl_checker.sv
dv/tb_console_serial_line_registers.sv
